/* rtl/rc_pwm_switch_decoder_unit_assert.svh */
// Assertion helpers shared by the decoder modules.
// Each use expects clk and rst to exist in the calling module.
`ifndef RC_PWM_SWITCH_DECODER_UNIT_ASSERT_SVH
`define RC_PWM_SWITCH_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RCPWM_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RCPWM_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rcpwm_pkg.sv */
`default_nettype none

package rcpwm_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned WidthW    = 16;
  localparam int unsigned MsW       = 16;
  localparam int unsigned CountW    = 32;

  localparam logic [WidthW-1:0] WidthSat = '1;
  localparam logic [MsW-1:0]    MsSat    = '1;

  // register indexes
  localparam logic [CfgIndexW-1:0] REG_MIN_PULSE  = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_MAX_PULSE  = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_LOW_THRESH = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_HIGH_THRESH = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_TIMEOUT    = 3'd4;

  // register reset values
  localparam logic [CfgDataW-1:0] MinPulseRst   = 16'd900;
  localparam logic [CfgDataW-1:0] MaxPulseRst   = 16'd2100;
  localparam logic [CfgDataW-1:0] LowThreshRst  = 16'd1300;
  localparam logic [CfgDataW-1:0] HighThreshRst = 16'd1700;
  localparam logic [CfgDataW-1:0] TimeoutRst   = 16'd500;

  // switch positions
  localparam logic [1:0] POS_UNKNOWN = 2'd0;
  localparam logic [1:0] POS_LOW     = 2'd1;
  localparam logic [1:0] POS_MIDDLE  = 2'd2;
  localparam logic [1:0] POS_HIGH    = 2'd3;

  typedef struct packed {
    logic pin_level;
    logic ms_tick;
  } sample_t;

  typedef struct packed {
    logic [WidthW-1:0] pulse_width_us;
    logic [WidthW-1:0] raw_width_us;
    logic              signal_ok;
    logic              in_failsafe;
    logic [1:0]        switch_pos;
    logic              rearm_seen;
    logic              cockpit_request;
    logic [CountW-1:0] measured_count;
    logic [CountW-1:0] rejected_count;
  } result_t;

  typedef struct packed {
    logic [CfgDataW-1:0] min_pulse_us;
    logic [CfgDataW-1:0] max_pulse_us;
    logic [CfgDataW-1:0] low_threshold_us;
    logic [CfgDataW-1:0] high_threshold_us;
    logic [CfgDataW-1:0] timeout_ms;
  } cfg_t;

  // one completed measurement, valid in the cycle it ends
  typedef struct packed {
    logic              done;
    logic              accept;
    logic [WidthW-1:0] width;
  } meas_t;

  // post-update measurement counters
  typedef struct packed {
    logic [WidthW-1:0] raw_width_us;
    logic [CountW-1:0] measured_count;
    logic [CountW-1:0] rejected_count;
  } counts_t;

  // post-update switch tracking status
  typedef struct packed {
    logic [WidthW-1:0] pulse_width_us;
    logic              failsafe;
    logic [1:0]        switch_pos;
    logic              rearm_seen;
  } track_t;

endpackage

`default_nettype wire

/* rtl/rcpwm_if.sv */
`default_nettype none

// Sample channel: one pin sample per beat.
interface rcpwm_sample_if;
  import rcpwm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// Result channel: one decoder status word per beat.
interface rcpwm_result_if;
  import rcpwm_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/rcpwm_cfg.sv */
`default_nettype none

module rcpwm_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_en,
  input  wire logic [rcpwm_pkg::CfgIndexW-1:0]  wr_index,
  input  wire logic [rcpwm_pkg::CfgDataW-1:0]   wr_data,
  output rcpwm_pkg::cfg_t                       cfg
);
  import rcpwm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_pulse_us      <= MinPulseRst;
      cfg.max_pulse_us      <= MaxPulseRst;
      cfg.low_threshold_us  <= LowThreshRst;
      cfg.high_threshold_us <= HighThreshRst;
      cfg.timeout_ms        <= TimeoutRst;
    end else if (wr_en) begin
      case (wr_index)
        REG_MIN_PULSE:   cfg.min_pulse_us      <= wr_data;
        REG_MAX_PULSE:   cfg.max_pulse_us      <= wr_data;
        REG_LOW_THRESH:  cfg.low_threshold_us  <= wr_data;
        REG_HIGH_THRESH: cfg.high_threshold_us <= wr_data;
        REG_TIMEOUT:     cfg.timeout_ms        <= wr_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/rcpwm_measure.sv */
`default_nettype none

module rcpwm_measure (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        level,
  input  rcpwm_pkg::cfg_t  cfg,
  output rcpwm_pkg::meas_t meas,
  output rcpwm_pkg::counts_t counts
);
  import rcpwm_pkg::*;

  logic              prev_level;
  logic              rise_seen;
  logic [WidthW-1:0] high_time;
  logic [WidthW-1:0] last_raw_width;
  logic [CountW-1:0] pulse_total;
  logic [CountW-1:0] reject_total;

  logic              rise_edge;
  logic              fall_edge;
  logic              in_window;
  logic              rise_seen_next;
  logic [WidthW-1:0] high_time_next;

  always_comb begin
    rise_edge = level && !prev_level;
    fall_edge = !level && prev_level && rise_seen;
    in_window = (high_time >= cfg.min_pulse_us) && (high_time <= cfg.max_pulse_us);

    rise_seen_next = rise_seen | rise_edge;
    if (rise_edge) begin
      high_time_next = WidthW'(1);
    end else if (level && rise_seen && (high_time != WidthSat)) begin
      high_time_next = high_time + WidthW'(1);
    end else begin
      high_time_next = high_time;
    end

    meas.done   = fall_edge;
    meas.accept = fall_edge && in_window;
    meas.width  = high_time;

    counts.raw_width_us   = fall_edge ? high_time : last_raw_width;
    counts.measured_count = pulse_total + CountW'(fall_edge);
    counts.rejected_count = reject_total + CountW'(fall_edge && !in_window);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level     <= 1'b0;
      rise_seen      <= 1'b0;
      high_time      <= '0;
      last_raw_width <= '0;
      pulse_total    <= '0;
      reject_total   <= '0;
    end else if (en) begin
      prev_level     <= level;
      rise_seen      <= rise_seen_next;
      high_time      <= high_time_next;
      last_raw_width <= counts.raw_width_us;
      pulse_total    <= counts.measured_count;
      reject_total   <= counts.rejected_count;
    end
  end

endmodule

`default_nettype wire

/* rtl/rcpwm_track.sv */
`default_nettype none
`include "rc_pwm_switch_decoder_unit_assert.svh"

module rcpwm_track (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         tick,
  input  rcpwm_pkg::meas_t  meas,
  input  rcpwm_pkg::cfg_t   cfg,
  output rcpwm_pkg::track_t status
);
  import rcpwm_pkg::*;

  logic [WidthW-1:0] accepted_width;
  logic              ever_valid;
  logic [MsW-1:0]    ms_since_valid;
  logic [1:0]        position;
  logic              rearm_flag;

  logic              is_low;
  logic [1:0]        class_pos;
  logic              ever_valid_next;
  logic [MsW-1:0]    ms_since_valid_next;
  logic [WidthW-1:0] width_mid;
  logic [1:0]        pos_mid;

  always_comb begin
    // low wins when the thresholds overlap
    is_low = meas.width < cfg.low_threshold_us;
    if (is_low) begin
      class_pos = POS_LOW;
    end else if (meas.width > cfg.high_threshold_us) begin
      class_pos = POS_HIGH;
    end else begin
      class_pos = POS_MIDDLE;
    end

    ever_valid_next = ever_valid | meas.accept;
    width_mid       = meas.accept ? meas.width : accepted_width;
    pos_mid         = meas.accept ? class_pos : position;

    // a tick in the same beat as an accepted pulse is swallowed
    if (meas.accept) begin
      ms_since_valid_next = '0;
    end else if (tick && (ms_since_valid != MsSat)) begin
      ms_since_valid_next = ms_since_valid + MsW'(1);
    end else begin
      ms_since_valid_next = ms_since_valid;
    end

    status.failsafe       = !ever_valid_next || (ms_since_valid_next > cfg.timeout_ms);
    status.pulse_width_us = status.failsafe ? '0 : width_mid;
    status.switch_pos     = status.failsafe ? POS_UNKNOWN : pos_mid;
    status.rearm_seen     = rearm_flag | (meas.accept && is_low);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_width <= '0;
      ever_valid     <= 1'b0;
      ms_since_valid <= '0;
      position       <= POS_UNKNOWN;
      rearm_flag     <= 1'b0;
    end else if (en) begin
      accepted_width <= status.pulse_width_us;
      ever_valid     <= ever_valid_next;
      ms_since_valid <= ms_since_valid_next;
      position       <= status.switch_pos;
      rearm_flag     <= status.rearm_seen;
    end
  end

  `RCPWM_CHECK_NEXT(a_accept_restarts, en && meas.accept,
    ever_valid && (ms_since_valid == '0), "accepted pulse did not restart timeout")
  `RCPWM_CHECK_NEXT(a_ever_valid_sticky, ever_valid, ever_valid, "ever_valid dropped")
  `RCPWM_CHECK_NEXT(a_rearm_sticky, rearm_flag, rearm_flag, "rearm flag dropped")
  `RCPWM_CHECK(a_unknown_no_width, ever_valid && (position == POS_UNKNOWN),
    accepted_width == '0, "width kept while position unknown")

endmodule

`default_nettype wire

/* rtl/rcpwm_outbuf.sv */
`default_nettype none
`include "rc_pwm_switch_decoder_unit_assert.svh"

module rcpwm_outbuf (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  rcpwm_pkg::result_t data,
  output logic              ready,
  rcpwm_result_if.source    result
);
  import rcpwm_pkg::*;

  logic    main_v;
  logic    skid_v;
  result_t main_q;
  result_t skid_q;

  assign ready          = !skid_v;
  assign result.valid   = main_v;
  assign result.payload = main_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (!main_v || result.ready) begin
      if (skid_v) begin
        main_q <= skid_q;
        main_v <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        main_v <= push;
        if (push) begin
          main_q <= data;
        end
      end
    end else if (push) begin
      skid_q <= data;
      skid_v <= 1'b1;
    end
  end

  `RCPWM_CHECK(a_skid_implies_main, skid_v, main_v, "skid filled with empty head")
  `RCPWM_CHECK(a_no_push_when_full, push, !skid_v, "beat pushed into full buffer")
  `RCPWM_CHECK_NEXT(a_skid_drains, skid_v && result.ready, main_v && !skid_v,
    "skid beat not moved to head")

endmodule

`default_nettype wire

/* rtl/rc_pwm_switch_decoder_unit.sv */
`default_nettype none

// RC PWM switch decoder. Each sample beat carries one microsecond sample of
// the receiver PWM pin plus a flag for a millisecond boundary. Each sample
// produces exactly one result beat with the decoder status after that
// sample: last accepted and last raw pulse width, failsafe and signal-ok,
// the three-position switch reading, the sticky rearm flag, the cockpit
// request and the wrapping measured and rejected pulse counts. Throughput
// is one sample per clock while the result side is ready. A sample is held
// in the input register, and its result is loaded into the result register
// and offered from there. All decode logic sits between the two registers.
// A second result entry catches the beat pushed during a result stall, so
// the input keeps accepting as a stall begins. Once that entry is full, the
// input pauses until the entry has moved to the head. The user must write
// thresholds, window and timeout through wr_en/wr_index/wr_data only while
// no samples are in flight; the block itself does not enforce this.
module rc_pwm_switch_decoder_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [rcpwm_pkg::CfgIndexW-1:0] wr_index,
  input  wire logic [rcpwm_pkg::CfgDataW-1:0]  wr_data,
  rcpwm_sample_if.sink                         sample,
  rcpwm_result_if.source                       result
);
  import rcpwm_pkg::*;

  cfg_t    cfg;
  meas_t   meas;
  counts_t counts;
  track_t  status;
  result_t res;

  // input register
  logic    in_v;
  sample_t in_q;

  logic    buf_ready;
  logic    push;

  // the held sample moves on whenever the result buffer has room
  assign push         = in_v && buf_ready;
  assign sample.ready = !in_v || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (sample.ready) begin
      in_v <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_q <= sample.payload;
    end
  end

  rcpwm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // edge detection, high-time counter, window check, counters
  rcpwm_measure u_measure (
    .clk    (clk),
    .rst    (rst),
    .en     (push),
    .level  (in_q.pin_level),
    .cfg    (cfg),
    .meas   (meas),
    .counts (counts)
  );

  // switch position, rearm latch, timeout and failsafe
  rcpwm_track u_track (
    .clk    (clk),
    .rst    (rst),
    .en     (push),
    .tick   (in_q.ms_tick),
    .meas   (meas),
    .cfg    (cfg),
    .status (status)
  );

  always_comb begin
    res.pulse_width_us  = status.pulse_width_us;
    res.raw_width_us    = counts.raw_width_us;
    res.signal_ok       = !status.failsafe;
    res.in_failsafe     = status.failsafe;
    res.switch_pos      = status.switch_pos;
    res.rearm_seen      = status.rearm_seen;
    // high position only survives when failsafe is clear
    res.cockpit_request = (status.switch_pos == POS_HIGH);
    res.measured_count  = counts.measured_count;
    res.rejected_count  = counts.rejected_count;
  end

  rcpwm_outbuf u_outbuf (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .data   (res),
    .ready  (buf_ready),
    .result (result)
  );

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none

// Testbench for the RC PWM switch decoder.
// Samples go in on one stream channel and status beats come out on the other.
// Every accepted sample is run through a local copy of the decoder. The status
// that copy predicts is queued and then compared, field by field, with the
// status beat that comes back. Both channels idle at random, and the
// configuration is changed only after every expected status has arrived.
module tb_top;
  import rcpwm_pkg::*;

  localparam int unsigned CycleLimit   = 100_000;
  localparam int unsigned RandomItems  = 720;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned SettleCycles = 6;   // pipeline is two deep, leave margin

  // mirror of the decoder's internal state
  typedef struct packed {
    logic              prev_level;
    logic              rise_seen;
    logic [WidthW-1:0] high_time;
    logic [WidthW-1:0] accepted_width;
    logic [WidthW-1:0] last_raw_width;
    logic              ever_valid;
    logic [MsW-1:0]    ms_since_valid;
    logic [1:0]        position;
    logic              rearm_flag;
    logic [CountW-1:0] pulse_total;
    logic [CountW-1:0] reject_total;
  } decoder_state_t;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [CfgIndexW-1:0] wr_index;
  logic [CfgDataW-1:0]  wr_data;

  rcpwm_sample_if smp_ch();
  rcpwm_result_if res_ch();

  rc_pwm_switch_decoder_unit uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .sample   (smp_ch),
    .result   (res_ch)
  );

  cfg_t           model_cfg;
  decoder_state_t model_st;
  result_t        status_q[$];      // predicted status beats, oldest first
  int unsigned    mismatches   = 0;
  int unsigned    cycle_count  = 0;
  int unsigned    samples_sent = 0;
  int unsigned    tick_div     = 0; // 0: no random ms ticks, n: about one in n
  int unsigned    stall_left   = 0;
  bit             idle_on      = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops beats.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side back-pressure: random stall bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, 3);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Decoder prediction for one sample; updates model_st and returns the
  // status the block should report after that sample.
  function automatic result_t decode_sample(input sample_t s);
    result_t           r;
    logic              taken;
    logic              failsafe;
    logic [WidthW-1:0] w;
    taken = 1'b0;
    if (s.pin_level && !model_st.prev_level) begin
      // rising edge starts a new measurement at one microsecond
      model_st.rise_seen = 1'b1;
      model_st.high_time = 1;
    end else if (s.pin_level) begin
      if (model_st.rise_seen && model_st.high_time != WidthSat)
        model_st.high_time = model_st.high_time + 1;
    end else if (model_st.prev_level && model_st.rise_seen) begin
      // falling edge: measurement complete
      w = model_st.high_time;
      model_st.last_raw_width = w;
      model_st.pulse_total    = model_st.pulse_total + 1;
      if (w >= model_cfg.min_pulse_us && w <= model_cfg.max_pulse_us) begin
        taken = 1'b1;
        model_st.accepted_width = w;
        model_st.ever_valid     = 1'b1;
        model_st.ms_since_valid = '0;
        // low wins when the thresholds overlap
        if (w < model_cfg.low_threshold_us) begin
          model_st.position   = POS_LOW;
          model_st.rearm_flag = 1'b1;
        end else if (w > model_cfg.high_threshold_us) begin
          model_st.position = POS_HIGH;
        end else begin
          model_st.position = POS_MIDDLE;
        end
      end else begin
        model_st.reject_total = model_st.reject_total + 1;
      end
    end
    model_st.prev_level = s.pin_level;

    // a tick on the same sample as an accepted pulse is swallowed
    if (!taken && s.ms_tick && model_st.ms_since_valid != MsSat)
      model_st.ms_since_valid = model_st.ms_since_valid + 1;

    failsafe = !model_st.ever_valid || (model_st.ms_since_valid > model_cfg.timeout_ms);
    if (failsafe) begin
      model_st.position       = POS_UNKNOWN;
      model_st.accepted_width = '0;
    end

    r.pulse_width_us  = model_st.accepted_width;
    r.raw_width_us    = model_st.last_raw_width;
    r.signal_ok       = !failsafe;
    r.in_failsafe     = failsafe;
    r.switch_pos      = model_st.position;
    r.rearm_seen      = model_st.rearm_flag;
    r.cockpit_request = (model_st.position == POS_HIGH);
    r.measured_count  = model_st.pulse_total;
    r.rejected_count  = model_st.reject_total;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [CountW-1:0] want,
                                      input logic [CountW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Predict on every accepted sample, compare on every accepted status beat.
  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (!rst) begin
      if (smp_ch.valid && smp_ch.ready)
        status_q.push_back(decode_sample(smp_ch.payload));
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.payload;
        if (status_q.size() == 0) begin
          $display("%0t: unexpected status beat, expected none, got %h", $time, got);
          mismatches++;
        end else begin
          want = status_q.pop_front();
          check_field("pulse_width_us", want.pulse_width_us, got.pulse_width_us);
          check_field("raw_width_us", want.raw_width_us, got.raw_width_us);
          check_field("signal_ok", want.signal_ok, got.signal_ok);
          check_field("in_failsafe", want.in_failsafe, got.in_failsafe);
          check_field("switch_pos", want.switch_pos, got.switch_pos);
          check_field("rearm_seen", want.rearm_seen, got.rearm_seen);
          check_field("cockpit_request", want.cockpit_request, got.cockpit_request);
          check_field("measured_count", want.measured_count, got.measured_count);
          check_field("rejected_count", want.rejected_count, got.rejected_count);
        end
      end
    end
  end

  function automatic logic tick_pick();
    return (tick_div != 0) && ($urandom_range(1, tick_div) == 1);
  endfunction

  // One sample beat; the sender may idle for a short burst first.
  task automatic send_sample(input logic pin, input logic tick);
    sample_t s;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      smp_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s.pin_level    = pin;
    s.ms_tick      = tick;
    smp_ch.valid   <= 1'b1;
    smp_ch.payload <= s;
    @(posedge clk);
    while (!smp_ch.ready) @(posedge clk);
    samples_sent++;
  endtask

  // width high samples, then the falling sample, then gap more low samples
  task automatic send_pulse(input int unsigned width, input int unsigned gap,
                            input logic edge_tick);
    repeat (width) send_sample(1'b1, tick_pick());
    send_sample(1'b0, edge_tick);
    repeat (gap) send_sample(1'b0, tick_pick());
  endtask

  // Stop sending and wait until every predicted status has been checked.
  task automatic wait_drain();
    smp_ch.valid <= 1'b0;
    @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_MIN_PULSE:   model_cfg.min_pulse_us      = val;
      REG_MAX_PULSE:   model_cfg.max_pulse_us      = val;
      REG_LOW_THRESH:  model_cfg.low_threshold_us  = val;
      REG_HIGH_THRESH: model_cfg.high_threshold_us = val;
      REG_TIMEOUT:     model_cfg.timeout_ms        = val;
      default: ;       // spare indexes are ignored
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input cfg_t c);
    wait_drain();
    write_reg(REG_MIN_PULSE, c.min_pulse_us);
    write_reg(REG_MAX_PULSE, c.max_pulse_us);
    write_reg(REG_LOW_THRESH, c.low_threshold_us);
    write_reg(REG_HIGH_THRESH, c.high_threshold_us);
    write_reg(REG_TIMEOUT, c.timeout_ms);
  endtask

  // Reset values: the window opens at 900 us, so short pulses are rejected
  // and failsafe holds. The first sample after reset is high, so it already
  // counts as a rising edge.
  task automatic test_reset_values();
    tick_div = 0;
    send_pulse(1, 2, 1'b0);
    send_pulse(40, 2, 1'b0);
    send_pulse(120, 2, 1'b1);
  endtask

  // Window and threshold edges with a small scale.
  task automatic test_window_edges();
    int unsigned widths[10] = '{3, 4, 8, 14, 15, 20, 21, 7, 1, 10};
    set_config('{16'd4, 16'd20, 16'd8, 16'd14, 16'd65534});
    foreach (widths[k]) send_pulse(widths[k], 2, 1'b0);
  endtask

  // Overlapping thresholds, inverted window, and register extremes.
  task automatic test_odd_settings();
    // low above high: 7 is under low and over high, low wins
    set_config('{16'd2, 16'd30, 16'd10, 16'd5, 16'd65534});
    send_pulse(7, 1, 1'b0);
    send_pulse(12, 1, 1'b0);
    // inverted window rejects everything
    set_config('{16'd20, 16'd5, 16'd8, 16'd14, 16'd65534});
    send_pulse(5, 1, 1'b0);
    send_pulse(12, 1, 1'b0);
    send_pulse(20, 1, 1'b0);
    // widest window, no low or high possible
    set_config('{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd65534});
    send_pulse(1, 1, 1'b0);
    send_pulse(33, 1, 1'b0);
    // everything low
    set_config('{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0});
    send_pulse(2, 1, 1'b0);
    // zero-width window
    set_config('{16'd0, 16'd0, 16'd8, 16'd14, 16'd65534});
    send_pulse(1, 1, 1'b0);
  endtask

  // Writes to indexes past the last register must change nothing.
  task automatic test_spare_index();
    int unsigned i;
    set_config('{16'd4, 16'd20, 16'd8, 16'd14, 16'd65534});
    for (i = REG_TIMEOUT + 1; i < (1 << CfgIndexW); i++)
      write_reg(CfgIndexW'(i), CfgDataW'($urandom));
    send_pulse(3, 1, 1'b0);
    send_pulse(21, 1, 1'b0);
    send_pulse(10, 1, 1'b0);
    send_pulse(16, 1, 1'b0);
  endtask

  // Millisecond timeout, including a tick on the accepting sample.
  task automatic test_timeout();
    tick_div = 0;
    set_config('{16'd2, 16'd30, 16'd10, 16'd20, 16'd3});
    send_pulse(12, 0, 1'b1);              // tick swallowed by the accept
    repeat (6) send_sample(1'b0, 1'b1);   // fourth tick trips failsafe
    send_pulse(25, 1, 1'b0);              // recovers as high
    set_config('{16'd2, 16'd30, 16'd10, 16'd20, 16'd0});
    send_pulse(5, 0, 1'b1);
    send_sample(1'b0, 1'b1);              // any tick trips a zero timeout
    send_pulse(15, 2, 1'b0);
  endtask

  function automatic logic [CfgDataW-1:0] rand_limit();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return CfgDataW'($urandom_range(0, 40));
    endcase
  endfunction

  // Random phases: mostly proper pulses with random widths and gaps, some
  // line noise, a new setting per phase. The last phase runs without idling.
  task automatic test_random();
    cfg_t        c;
    int unsigned phase;
    int unsigned stop_at;
    for (phase = 0; phase < RandomPhases; phase++) begin
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        c.min_pulse_us      = CfgDataW'($urandom_range(1, 6));
        c.max_pulse_us      = CfgDataW'($urandom_range(18, 32));
        c.low_threshold_us  = CfgDataW'($urandom_range(6, 12));
        c.high_threshold_us = CfgDataW'($urandom_range(12, 20));
      end else begin
        c.min_pulse_us      = rand_limit();
        c.max_pulse_us      = rand_limit();
        c.low_threshold_us  = rand_limit();
        c.high_threshold_us = rand_limit();
      end
      c.timeout_ms = ($urandom_range(0, 7) == 0) ? 16'd65534 : CfgDataW'($urandom_range(0, 15));
      set_config(c);
      tick_div = $urandom_range(0, 6);
      idle_on  = (phase != RandomPhases - 1);
      stop_at  = samples_sent + RandomItems / RandomPhases;
      while (samples_sent < stop_at) begin
        if ($urandom_range(0, 39) == 0)
          wait_drain();                   // sender holds off until all is checked
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 6))
            send_sample($urandom_range(0, 1), $urandom_range(0, 1));
        else
          send_pulse($urandom_range(1, 35), $urandom_range(0, 8), tick_pick());
      end
    end
  endtask

  initial begin
    rst            <= 1'b1;
    wr_en          <= 1'b0;
    wr_index       <= '0;
    wr_data        <= '0;
    smp_ch.valid   <= 1'b0;
    smp_ch.payload <= '0;
    model_cfg = '{MinPulseRst, MaxPulseRst, LowThreshRst, HighThreshRst, TimeoutRst};
    model_st  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_window_edges();
    test_odd_settings();
    test_spare_index();
    test_timeout();
    test_random();
    wait_drain();

    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
